// File: sv/rcid_pkg.sv
package rcid_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int MAP_W     = 2 * WORD_W;
    localparam int OPCODE_W  = 2;
    localparam int ID_W      = 10;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 16;
    localparam int CFG_W     = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_USE     = 2'd1,
        OP_DISCARD = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE    = 2'd0,
        STS_FULL    = 2'd1,
        STS_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_WR,
        S_REF_CHK,
        S_DONE
    } state_t;

endpackage

// File: sv/rcid_req_if.sv
interface rcid_req_if;
    import rcid_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     target_id;

    modport source (output valid, opcode, target_id, input ready);
    modport sink   (input valid, opcode, target_id, output ready);
endinterface

// File: sv/rcid_rsp_if.sv
interface rcid_rsp_if;
    import rcid_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      result_id;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] use_count_after;
    logic                 freed;

    modport source (output valid, result_id, status, use_count_after, freed, input ready);
    modport sink   (input valid, result_id, status, use_count_after, freed, output ready);
endinterface

// File: sv/rcid_ram.sv
module rcid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/rcid_find.sv
module rcid_find (
    input  logic [rcid_pkg::WORD_W-1:0] used_word,
    output logic                        found,
    output logic [rcid_pkg::BIT_W-1:0]  idx
);
    import rcid_pkg::*;

    localparam int GRP_W = 8;
    localparam int NGRP  = WORD_W / GRP_W;
    localparam int GB    = $clog2(GRP_W);
    localparam int NB    = BIT_W - GB;

    logic [NGRP-1:0] grp_free;
    logic [GB-1:0]   grp_idx [NGRP];

    // lowest clear bit inside each byte
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free[g] = 1'b0;
            grp_idx[g]  = '0;
            for (int b = GRP_W - 1; b >= 0; b--)
            begin
                if (!used_word[g*GRP_W + b])
                begin
                    grp_free[g] = 1'b1;
                    grp_idx[g]  = GB'(b);
                end
            end
        end
    end

    // lowest byte that has one
    always_comb
    begin
        found = |grp_free;
        idx   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                idx = {NB'(g), grp_idx[g]};
            end
        end
    end

endmodule

// File: sv/refcounted_id_allocator_top.sv
// Channel  Dir  Beat contents
// -------  ---  ------------------------------------------------
// req      in   opcode, target_id
// rsp      out  result_id, status, use_count_after, freed
// cfg      in   fixed_count (cfg_we / cfg_wdata, write only)
//
// One request at a time. Use and discard: map and count read, update, result.
// Allocate: one map word read and checked per step, from the cursor's word to the last
// word, then after a wrap from the base word up to the first word read; then the id is
// marked used and the result goes out.
// Restart: one map word rewritten per cycle, then the result.
// After reset a clearing pass zeroes every map word; req.ready stays low.
// A result waits in the rsp register while the next request is taken.
module refcounted_id_allocator_top #(
    parameter int CAPACITY   = rcid_pkg::CAPACITY_DEF,
    parameter int COUNT_BITS = rcid_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rcid_req_if.sink                  req,
    rcid_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [rcid_pkg::CFG_W-1:0] cfg_wdata
);
    import rcid_pkg::*;

    localparam int WORDS    = CAPACITY / WORD_W;
    localparam int ID_LIMIT = WORDS * WORD_W;
    localparam int CB       = $clog2(ID_LIMIT + 1);
    localparam int IDB      = $clog2(ID_LIMIT);
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WVB      = $clog2(WORDS + 1);
    localparam int TW       = ((CB > CFG_W) ? CB : CFG_W) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [WVB-1:0]        WORDS_C    = WVB'(WORDS);
    localparam logic [CB-1:0]         LIMIT_C    = CB'(ID_LIMIT);
    localparam logic [TW-1:0]         LIMIT_T    = TW'(ID_LIMIT);
    localparam logic [AW-1:0]         SWEEP_LAST = AW'(WORDS - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] fixed_count_reg, fixed_count_next;
    logic [CB-1:0]    cursor_reg, cursor_next;
    logic [CB-1:0]    base_reg, base_next;
    logic [AW-1:0]    sweep_w_reg, sweep_w_next;
    logic [CB-1:0]    sweep_n_reg, sweep_n_next;
    logic             restart_reg, restart_next;
    logic             out_valid_reg, out_valid_next;

    op_t              op_reg, op_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [WVB-1:0]   scan_w_reg, scan_w_next;
    logic [WVB-1:0]   ini_reg, ini_next;
    logic             phase_reg, phase_next;
    logic             chk_cur_reg, chk_cur_next;
    logic [IDB-1:0]   got_id_reg, got_id_next;
    logic [BIT_W-1:0] got_bit_reg, got_bit_next;

    logic [ID_W-1:0]      res_id_reg, res_id_next;
    status_t              res_status_reg, res_status_next;
    logic [CNT_OUT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 res_freed_reg, res_freed_next;

    logic [ID_W-1:0]      out_id_reg, out_id_next;
    status_t              out_status_reg, out_status_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 out_freed_reg, out_freed_next;

    logic                  map_wr_en, map_rd_en;
    logic [AW-1:0]         map_wr_addr, map_rd_addr;
    logic [MAP_W-1:0]      map_wr_data, map_rd_data;
    logic                  cnt_wr_en, cnt_rd_en;
    logic [IDB-1:0]        cnt_wr_addr, cnt_rd_addr;
    logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd_data;

    logic [WORD_W-1:0] used_half, stale_half;
    logic              find_found;
    logic [BIT_W-1:0]  find_idx;

    logic [WVB-1:0]        cur_word, base_word;
    logic                  tid_ok_in, scan_in_range, cur_free, load_out;
    logic [BIT_W-1:0]      t_bit;
    logic                  t_used, t_stale;
    logic [WORD_W-1:0]     t_mask;
    logic [COUNT_BITS-1:0] cur_cnt, inc_cnt, dec_cnt;
    logic [TW-1:0]         fix_n, fix_top;
    logic [CB-1:0]         sweep_nw;
    logic [WORD_W-1:0]     sweep_mask;

    rcid_ram #(.WIDTH(MAP_W), .DEPTH(WORDS)) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    rcid_ram #(.WIDTH(COUNT_BITS), .DEPTH(ID_LIMIT)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // Each map entry holds the used bits and, above them, a zero-count mark:
    // a set mark means the count memory entry is stale and reads as zero.
    assign used_half  = map_rd_data[WORD_W-1:0];
    assign stale_half = map_rd_data[MAP_W-1:WORD_W];

    rcid_find u_find (
        .used_word (used_half),
        .found     (find_found),
        .idx       (find_idx)
    );

    assign cur_word  = WVB'(cursor_reg >> BIT_W);
    assign base_word = WVB'(base_reg >> BIT_W);
    assign tid_ok_in = TW'(req.target_id) < LIMIT_T;

    assign scan_in_range = (scan_w_reg < WORDS_C) && (!phase_reg || (scan_w_reg < ini_reg));
    assign cur_free      = chk_cur_reg && !used_half[cursor_reg[BIT_W-1:0]];

    assign t_bit   = tid_reg[BIT_W-1:0];
    assign t_used  = used_half[t_bit];
    assign t_stale = stale_half[t_bit];
    assign t_mask  = WORD_W'(1) << t_bit;
    assign cur_cnt = t_stale ? '0 : cnt_rd_data;
    assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
    assign dec_cnt = cur_cnt - COUNT_BITS'(1);

    assign fix_n   = (TW'(fixed_count_reg) > LIMIT_T) ? LIMIT_T : TW'(fixed_count_reg);
    assign fix_top = ((fix_n + TW'(WORD_W)) & ~TW'(WORD_W - 1)) > LIMIT_T
                     ? LIMIT_T : ((fix_n + TW'(WORD_W)) & ~TW'(WORD_W - 1));

    assign sweep_nw = sweep_n_reg >> BIT_W;
    always_comb
    begin
        if (CB'(sweep_w_reg) < sweep_nw)
        begin
            sweep_mask = '1;
        end
        else if (CB'(sweep_w_reg) == sweep_nw)
        begin
            sweep_mask = (WORD_W'(1) << sweep_n_reg[BIT_W-1:0]) - WORD_W'(1);
        end
        else
        begin
            sweep_mask = '0;
        end
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_w_reg == SWEEP_LAST)
                begin
                    state_next = restart_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (op_t'(req.opcode))
                        OP_ALLOC:               state_next = S_SCAN_RD;
                        OP_USE, OP_DISCARD:     state_next = tid_ok_in ? S_REF_CHK : S_DONE;
                        OP_RESTART:             state_next = S_CLEAR;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (scan_in_range)
                begin
                    state_next = S_SCAN_CHK;
                end
                else if (phase_reg || (ini_reg == base_word))
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CHK: state_next = (cur_free || find_found) ? S_ALLOC_WR : S_SCAN_RD;
            S_ALLOC_WR: state_next = S_DONE;
            S_REF_CHK:  state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        fixed_count_next = cfg_we ? cfg_wdata : fixed_count_reg;
        cursor_next      = cursor_reg;
        base_next        = base_reg;
        sweep_w_next     = sweep_w_reg;
        sweep_n_next     = sweep_n_reg;
        restart_next     = restart_reg;
        op_next          = op_reg;
        tid_next         = tid_reg;
        scan_w_next      = scan_w_reg;
        ini_next         = ini_reg;
        phase_next       = phase_reg;
        chk_cur_next     = chk_cur_reg;
        got_id_next      = got_id_reg;
        got_bit_next     = got_bit_reg;
        res_id_next      = res_id_reg;
        res_status_next  = res_status_reg;
        res_cnt_next     = res_cnt_reg;
        res_freed_next   = res_freed_reg;

        map_wr_en   = 1'b0;
        map_wr_addr = scan_w_reg[AW-1:0];
        map_wr_data = map_rd_data;
        map_rd_en   = 1'b0;
        map_rd_addr = scan_w_reg[AW-1:0];
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = IDB'(tid_reg);
        cnt_wr_data = inc_cnt;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = IDB'(req.target_id);

        unique case (state_reg)
            S_CLEAR:
            begin
                map_wr_en    = 1'b1;
                map_wr_addr  = sweep_w_reg;
                map_wr_data  = {sweep_mask, sweep_mask};
                sweep_w_next = sweep_w_reg + AW'(1);
                if (sweep_w_reg == SWEEP_LAST)
                begin
                    sweep_w_next = '0;
                    restart_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = op_t'(req.opcode);
                    tid_next        = req.target_id;
                    res_id_next     = '0;
                    res_status_next = STS_DONE;
                    res_cnt_next    = '0;
                    res_freed_next  = 1'b0;
                    unique case (op_t'(req.opcode))
                        OP_ALLOC:
                        begin
                            phase_next = 1'b0;
                            if (cursor_reg < LIMIT_C)
                            begin
                                scan_w_next  = cur_word;
                                ini_next     = cur_word;
                                chk_cur_next = 1'b1;
                            end
                            else
                            begin
                                scan_w_next  = base_word;
                                ini_next     = base_word;
                                chk_cur_next = 1'b0;
                            end
                        end
                        OP_USE, OP_DISCARD:
                        begin
                            res_id_next = req.target_id;
                            if (tid_ok_in)
                            begin
                                map_rd_en   = 1'b1;
                                map_rd_addr = AW'(req.target_id >> BIT_W);
                                cnt_rd_en   = 1'b1;
                            end
                            else
                            begin
                                res_status_next = STS_INVALID;
                            end
                        end
                        OP_RESTART:
                        begin
                            base_next    = CB'(fix_top);
                            cursor_next  = CB'(fix_top);
                            sweep_n_next = CB'(fix_n);
                            sweep_w_next = '0;
                            restart_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (scan_in_range)
                begin
                    map_rd_en = 1'b1;
                end
                else if (!phase_reg && (ini_reg != base_word))
                begin
                    // wrap round to the first word wholly above id fixed_count
                    scan_w_next = base_word;
                    phase_next  = 1'b1;
                end
                else
                begin
                    res_status_next = STS_FULL;
                end
            end
            S_SCAN_CHK:
            begin
                chk_cur_next = 1'b0;
                if (cur_free)
                begin
                    got_id_next  = IDB'(cursor_reg);
                    got_bit_next = cursor_reg[BIT_W-1:0];
                end
                else if (find_found)
                begin
                    got_id_next  = (IDB'(scan_w_reg) << BIT_W) | IDB'(find_idx);
                    got_bit_next = find_idx;
                end
                else
                begin
                    scan_w_next = scan_w_reg + WVB'(1);
                end
            end
            S_ALLOC_WR:
            begin
                // mark used, count reads as zero until first written
                map_wr_en    = 1'b1;
                map_wr_data  = map_rd_data | {WORD_W'(1) << got_bit_reg, WORD_W'(1) << got_bit_reg};
                cursor_next  = CB'(got_id_reg) + CB'(1);
                res_id_next  = ID_W'(got_id_reg);
            end
            S_REF_CHK:
            begin
                map_wr_addr = AW'(tid_reg >> BIT_W);
                if (op_reg == OP_USE)
                begin
                    if (!t_used)
                    begin
                        res_status_next = STS_INVALID;
                    end
                    else
                    begin
                        cnt_wr_en    = 1'b1;
                        cnt_wr_data  = inc_cnt;
                        res_cnt_next = CNT_OUT_W'(inc_cnt);
                        if (t_stale)
                        begin
                            map_wr_en   = 1'b1;
                            map_wr_data = map_rd_data & ~{t_mask, WORD_W'(0)};
                        end
                    end
                end
                else
                begin
                    if (!t_used || (cur_cnt == '0))
                    begin
                        res_status_next = STS_INVALID;
                    end
                    else
                    begin
                        cnt_wr_en    = 1'b1;
                        cnt_wr_data  = dec_cnt;
                        res_cnt_next = CNT_OUT_W'(dec_cnt);
                        // ids below the base, the fixed ones among them, stay used at zero
                        if ((dec_cnt == '0) && (TW'(tid_reg) >= TW'(base_reg)))
                        begin
                            map_wr_en      = 1'b1;
                            map_wr_data    = map_rd_data & ~{WORD_W'(0), t_mask};
                            res_freed_next = 1'b1;
                        end
                    end
                end
            end
            S_DONE:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = (out_valid_reg && !rsp.ready) || load_out;
        out_id_next     = load_out ? res_id_reg : out_id_reg;
        out_status_next = load_out ? res_status_reg : out_status_reg;
        out_cnt_next    = load_out ? res_cnt_reg : out_cnt_reg;
        out_freed_next  = load_out ? res_freed_reg : out_freed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            fixed_count_reg <= '0;
            cursor_reg      <= '0;
            base_reg        <= '0;
            sweep_w_reg     <= '0;
            sweep_n_reg     <= '0;
            restart_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fixed_count_reg <= fixed_count_next;
            cursor_reg      <= cursor_next;
            base_reg        <= base_next;
            sweep_w_reg     <= sweep_w_next;
            sweep_n_reg     <= sweep_n_next;
            restart_reg     <= restart_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tid_reg        <= tid_next;
        scan_w_reg     <= scan_w_next;
        ini_reg        <= ini_next;
        phase_reg      <= phase_next;
        chk_cur_reg    <= chk_cur_next;
        got_id_reg     <= got_id_next;
        got_bit_reg    <= got_bit_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        res_cnt_reg    <= res_cnt_next;
        res_freed_reg  <= res_freed_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_freed_reg  <= out_freed_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.result_id       = out_id_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.use_count_after = out_cnt_reg;
    assign rsp.freed           = out_freed_reg;

endmodule
